// ----- src/h3fp_pkg.sv -----
// Shared types and constants for the HTTP/3 frame parser.
// Used by h3fp_varint and http3_frame_parser; no dependencies.
package h3fp_pkg;

    // Width of a decoded QUIC variable-length integer.
    localparam int VARINT_W = 62;

    // Result event codes.
    localparam logic [2:0] EV_CONSUMED     = 3'd0;
    localparam logic [2:0] EV_TYPE         = 3'd1;
    localparam logic [2:0] EV_LEN          = 3'd2;
    localparam logic [2:0] EV_PAYLOAD      = 3'd3;
    localparam logic [2:0] EV_FIELD        = 3'd4;
    localparam logic [2:0] EV_SETTING      = 3'd5;
    localparam logic [2:0] EV_NOT_CONSUMED = 3'd6;
    localparam logic [2:0] EV_ERROR        = 3'd7;

    // Frame type codes that get special handling.
    localparam logic [VARINT_W-1:0] FT_DATA      = VARINT_W'(64'h0);
    localparam logic [VARINT_W-1:0] FT_HEADERS   = VARINT_W'(64'h1);
    localparam logic [VARINT_W-1:0] FT_CANCEL    = VARINT_W'(64'h3);
    localparam logic [VARINT_W-1:0] FT_SETTINGS  = VARINT_W'(64'h4);
    localparam logic [VARINT_W-1:0] FT_PROMISE   = VARINT_W'(64'h5);
    localparam logic [VARINT_W-1:0] FT_GOAWAY    = VARINT_W'(64'h7);
    localparam logic [VARINT_W-1:0] FT_PID_LIMIT = VARINT_W'(64'hd);

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_TYPE    = 4'b0001,
        PH_LEN     = 4'b0010,
        PH_PAYLOAD = 4'b0100,
        PH_END     = 4'b1000
    } phase_t;

    // How the payload of a frame is handled.
    typedef enum logic [2:0] {
        FC_PASS,      // DATA, HEADERS: bytes reported as not consumed
        FC_SINGLE,    // push cancel, GOAWAY, push id limit: one varint
        FC_SETTINGS,  // identifier and value pairs
        FC_PUSH,      // push id, then field-section bytes
        FC_SKIP       // unknown or reserved: skipped by length
    } frame_class_t;

    // Control from the parser to the varint decoder.
    typedef struct packed {
        logic feed;
        logic restart;
    } vi_ctrl_t;

    // Decoder outcome for the byte currently presented.
    typedef struct packed {
        logic                done;
        logic [VARINT_W-1:0] value;
    } vi_result_t;

    // Sorts a frame type into its payload handling class.
    function automatic frame_class_t classify(input logic [VARINT_W-1:0] ftype);
        frame_class_t fc;
        if (ftype == FT_DATA || ftype == FT_HEADERS) begin
            fc = FC_PASS;
        end else if (ftype == FT_CANCEL || ftype == FT_GOAWAY ||
                     ftype == FT_PID_LIMIT) begin
            fc = FC_SINGLE;
        end else if (ftype == FT_SETTINGS) begin
            fc = FC_SETTINGS;
        end else if (ftype == FT_PROMISE) begin
            fc = FC_PUSH;
        end else begin
            fc = FC_SKIP;
        end
        return fc;
    endfunction

endpackage

// ----- src/http3_frame_parser.sv -----
// HTTP/3 frame parser top level: byte input channel, one result per data byte.
// Depends on h3fp_pkg and h3fp_varint.
//
//   Channel  Dir  Handshake          Payload
//   s_       in   s_valid/s_ready    s_kind, s_data_byte
//   m_       out  m_valid/m_ready    m_event_res, m_frame_type, m_value,
//                                    m_setting_id, m_payload_byte, m_frame_end
//
// One byte is taken per cycle while no data result is stalled. A byte lands in
// an input register; its result is computed from that register and loaded into
// the output register once that register is free. A restart transaction
// gives no result and is retired from the input register even while a result
// is stalled. While m_ready is low the input register holds one more byte.
// Reset is synchronous, active low, and returns the parser to expecting a type.
module http3_frame_parser
    import h3fp_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_kind,
    input  logic [7:0]          s_data_byte,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_event_res,
    output logic [VARINT_W-1:0] m_frame_type,
    output logic [VARINT_W-1:0] m_value,
    output logic [VARINT_W-1:0] m_setting_id,
    output logic [7:0]          m_payload_byte,
    output logic                m_frame_end
);

    // Input register.
    logic       in_valid_reg;
    logic       in_kind_reg;
    logic [7:0] in_byte_reg;

    // Parser state.
    phase_t              phase_reg, phase_next;
    frame_class_t        class_reg, class_next;
    logic [VARINT_W-1:0] ftype_reg, ftype_next;
    logic [VARINT_W-1:0] remain_reg, remain_next;
    logic                pid_done_reg, pid_done_next;
    logic [VARINT_W-1:0] held_id_reg, held_id_next;
    logic                pending_reg, pending_next;

    // Output register.
    logic                m_valid_reg;
    logic [2:0]          ev_reg;
    logic [VARINT_W-1:0] ftype_out_reg;
    logic [VARINT_W-1:0] value_reg;
    logic [VARINT_W-1:0] sid_reg;
    logic [7:0]          pbyte_reg;
    logic                fin_reg;

    // Result of the byte in the input register.
    logic [2:0]          ev_next;
    logic [VARINT_W-1:0] value_next;
    logic [VARINT_W-1:0] sid_next;
    logic [7:0]          pbyte_next;
    logic                fin_next;

    logic                out_free;
    logic                proc;
    logic                restart;
    logic [VARINT_W-1:0] remain_dec;
    vi_ctrl_t            vi_ctrl;
    vi_result_t          vi_res;

    // A restart retires at once; a data byte needs room in the output register.
    assign out_free = !m_valid_reg || m_ready;
    assign proc     = in_valid_reg && (in_kind_reg || out_free);
    assign restart  = proc && in_kind_reg;
    assign s_ready  = !in_valid_reg || proc;

    assign remain_dec = remain_reg - VARINT_W'(1);

    h3fp_varint u_varint (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctrl      (vi_ctrl),
        .data_byte (in_byte_reg),
        .result    (vi_res)
    );

    // Frame parsing for one data byte.
    always_comb begin
        phase_next    = phase_reg;
        class_next    = class_reg;
        ftype_next    = ftype_reg;
        remain_next   = remain_reg;
        pid_done_next = pid_done_reg;
        held_id_next  = held_id_reg;
        pending_next  = pending_reg;
        ev_next       = EV_CONSUMED;
        value_next    = '0;
        sid_next      = '0;
        pbyte_next    = '0;
        fin_next      = 1'b0;
        vi_ctrl.feed    = 1'b0;
        vi_ctrl.restart = restart;

        unique case (phase_reg)
            PH_TYPE: begin
                vi_ctrl.feed = 1'b1;
                if (vi_res.done) begin
                    ftype_next = vi_res.value;
                    class_next = classify(vi_res.value);
                    phase_next = PH_LEN;
                    ev_next    = EV_TYPE;
                end
            end
            PH_LEN: begin
                vi_ctrl.feed = 1'b1;
                if (vi_res.done) begin
                    ev_next       = EV_LEN;
                    value_next    = vi_res.value;
                    remain_next   = vi_res.value;
                    pid_done_next = 1'b0;
                    held_id_next  = '0;
                    pending_next  = 1'b0;
                    if (vi_res.value == '0) begin
                        fin_next   = 1'b1;
                        phase_next = PH_END;
                    end else begin
                        phase_next = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD: begin
                case (class_reg)
                    FC_PASS: begin
                        ev_next = EV_NOT_CONSUMED;
                    end
                    FC_SINGLE: begin
                        vi_ctrl.feed = 1'b1;
                        if (vi_res.done) begin
                            ev_next    = EV_FIELD;
                            value_next = vi_res.value;
                            fin_next   = 1'b1;
                            phase_next = PH_END;
                        end
                    end
                    FC_SETTINGS: begin
                        vi_ctrl.feed = 1'b1;
                        remain_next  = remain_dec;
                        if (vi_res.done && pending_reg) begin
                            ev_next      = EV_SETTING;
                            sid_next     = held_id_reg;
                            value_next   = vi_res.value;
                            pending_next = 1'b0;
                        end else if (vi_res.done) begin
                            held_id_next = vi_res.value;
                            pending_next = 1'b1;
                        end
                        // Length used up: a half-parsed varint or pair is an error.
                        if (remain_dec == '0) begin
                            fin_next   = 1'b1;
                            phase_next = PH_END;
                            if (!vi_res.done || pending_next) begin
                                ev_next    = EV_ERROR;
                                sid_next   = '0;
                                value_next = '0;
                            end
                        end
                    end
                    FC_PUSH: begin
                        remain_next = remain_dec;
                        if (!pid_done_reg) begin
                            vi_ctrl.feed = 1'b1;
                            if (vi_res.done) begin
                                ev_next       = EV_FIELD;
                                value_next    = vi_res.value;
                                pid_done_next = 1'b1;
                            end else if (remain_dec == '0) begin
                                ev_next = EV_ERROR;
                            end
                        end else begin
                            ev_next    = EV_PAYLOAD;
                            pbyte_next = in_byte_reg;
                        end
                        if (remain_dec == '0) begin
                            fin_next   = 1'b1;
                            phase_next = PH_END;
                        end
                    end
                    default: begin
                        remain_next = remain_dec;
                        if (remain_dec == '0) begin
                            fin_next   = 1'b1;
                            phase_next = PH_END;
                        end
                    end
                endcase
            end
            default: begin
                ev_next = EV_ERROR;
            end
        endcase

        // Only a data byte that is retired this cycle moves the decoder.
        if (!(proc && !in_kind_reg)) begin
            vi_ctrl.feed = 1'b0;
        end
    end

    // Input register: holds one transaction until it is retired.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_valid_reg <= 1'b1;
        end else if (proc) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg <= s_kind;
            in_byte_reg <= s_data_byte;
        end
    end

    // Parser state update.
    always_ff @(posedge aclk) begin
        if (!aresetn || restart) begin
            phase_reg    <= PH_TYPE;
            class_reg    <= FC_PASS;
            ftype_reg    <= '0;
            remain_reg   <= '0;
            pid_done_reg <= 1'b0;
            held_id_reg  <= '0;
            pending_reg  <= 1'b0;
        end else if (proc) begin
            phase_reg    <= phase_next;
            class_reg    <= class_next;
            ftype_reg    <= ftype_next;
            remain_reg   <= remain_next;
            pid_done_reg <= pid_done_next;
            held_id_reg  <= held_id_next;
            pending_reg  <= pending_next;
        end
    end

    // Output register valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (proc && !in_kind_reg) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // Output register payload.
    always_ff @(posedge aclk) begin
        if (proc && !in_kind_reg) begin
            ev_reg        <= ev_next;
            ftype_out_reg <= ftype_next;
            value_reg     <= value_next;
            sid_reg       <= sid_next;
            pbyte_reg     <= pbyte_next;
            fin_reg       <= fin_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_event_res    = ev_reg;
    assign m_frame_type   = ftype_out_reg;
    assign m_value        = value_reg;
    assign m_setting_id   = sid_reg;
    assign m_payload_byte = pbyte_reg;
    assign m_frame_end    = fin_reg;

    // A retired data byte always leaves a result behind.
    a_byte_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !in_kind_reg |=> m_valid)
        else $error("retired data byte produced no result");

    // The payload phase is only entered with bytes still to come.
    a_payload_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> remain_reg != '0)
        else $error("payload phase with zero bytes remaining");

    // A held setting identifier only exists inside a SETTINGS frame.
    a_pending_settings: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg |-> class_reg == FC_SETTINGS)
        else $error("setting value pending outside a SETTINGS frame");

    // A result that closes a frame moves the parser into the end phase.
    a_end_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        proc && !in_kind_reg && fin_next |=> phase_reg == PH_END || $past(restart))
        else $error("frame end without entering the end phase");

endmodule

// ----- src/h3fp_varint.sv -----
// QUIC variable-length integer decoder, one byte per feed.
// Depends on h3fp_pkg.
module h3fp_varint
    import h3fp_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  vi_ctrl_t   ctrl,
    input  logic [7:0] data_byte,
    output vi_result_t result
);

    logic [VARINT_W-1:0] acc_reg;
    logic [VARINT_W-1:0] acc_next;
    logic [2:0]          left_reg;
    logic [2:0]          left_next;
    logic [VARINT_W-1:0] acc_new;
    logic [2:0]          left_new;

    // A zero byte count means this byte opens a new varint and carries its size.
    always_comb begin
        if (left_reg == 3'd0) begin
            acc_new = {{(VARINT_W-6){1'b0}}, data_byte[5:0]};
            case (data_byte[7:6])
                2'd0:    left_new = 3'd0;
                2'd1:    left_new = 3'd1;
                2'd2:    left_new = 3'd3;
                default: left_new = 3'd7;
            endcase
        end else begin
            acc_new  = {acc_reg[VARINT_W-9:0], data_byte};
            left_new = left_reg - 3'd1;
        end
        result.done  = (left_new == 3'd0);
        result.value = acc_new;
    end

    // Next state: restart clears, a completed varint empties the accumulator.
    always_comb begin
        acc_next  = acc_reg;
        left_next = left_reg;
        if (ctrl.restart) begin
            acc_next  = '0;
            left_next = 3'd0;
        end else if (ctrl.feed) begin
            left_next = left_new;
            acc_next  = result.done ? '0 : acc_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg  <= '0;
            left_reg <= 3'd0;
        end else begin
            acc_reg  <= acc_next;
            left_reg <= left_next;
        end
    end

endmodule
